// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/hes_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hes_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 12;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MU_DT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQRT_DT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA_DT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_VAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_VAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CORR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPOT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR = 3'd7;
endpackage
`default_nettype wire

// ----- hw/rtl/hes_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Floor integer square root, two radicand bits per cycle.
module hes_isqrt #(
    parameter int IN_W = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [IN_W-1:0] radicand,
    output logic busy,
    output logic [IN_W/2-1:0] root
);
    localparam int HW = IN_W / 2;
    localparam int CNT_W = $clog2(HW + 1);
    logic [IN_W-1:0] x_reg;
    logic [HW+1:0] rem_reg;
    logic [HW-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [HW+1:0] trial;
    logic [HW+1:0] rem_shift;

    // One restoring step: bring down two bits, try 4r+1.
    always_comb
    begin
        rem_shift = {rem_reg[HW-1:0], x_reg[IN_W-1:IN_W-2]};
        trial = {root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(HW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= radicand;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            x_reg <= {x_reg[IN_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg <= rem_shift - trial;
                root_reg <= {root_reg[HW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                root_reg <= {root_reg[HW-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/hes_serial_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Signed multiplier, one bit of the multiplier per cycle (shift and add).
module hes_serial_mul #(
    parameter int A_W = 40,
    parameter int B_W = 40
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [A_W-1:0] a,
    input  wire logic signed [B_W-1:0] b,
    output logic busy,
    output logic signed [A_W+B_W-1:0] product
);
    localparam int P_W = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);
    logic signed [P_W-1:0] acc_reg;
    logic signed [P_W-1:0] mcand_reg;
    logic [B_W-1:0] mplier_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(B_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // The top multiplier bit carries negative weight.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mcand_reg <= P_W'(a);
            mplier_reg <= b;
        end
        else if (cnt_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    acc_reg <= acc_reg - mcand_reg;
                end
                else
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
            end
            mcand_reg <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign busy = (cnt_reg != '0);
    assign product = acc_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/heston_euler_path_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Heston path stepper: one Euler step with full truncation per request.
// Input channel (in_valid/in_ready) carries start_path, z_price, z_second.
// Output channel (out_valid/out_ready) returns price, variance, saturated
// and variance_truncated for every input request.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the eight parameter registers; write only while the block is idle.
// A step runs on one shared serial square root unit (two bits per cycle)
// and one shared shift-add multiplier (one bit per cycle). A step is one
// root pass and nine multiplies; a path start adds one product and one
// root pass. One request is in work at a time; the next one can be accepted
// in the same cycle as the result appears, not before.
// A result sits in the output register until taken. The next request runs
// meanwhile but holds at the end of its last multiply until the register
// is free, and the input stays closed, so a stalled receiver holds the block.
// Reset loads the register defaults, sets price and variance from spot
// and initial variance, and clears the correlation complement.
module heston_euler_path_step
    import hes_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic start_path,
    input  wire logic signed [15:0] z_price,
    input  wire logic signed [15:0] z_second,
    output logic out_valid,
    input  wire logic out_ready,
    output logic signed [31:0] price,
    output logic [30:0] variance,
    output logic saturated,
    output logic variance_truncated,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [hes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int MW = 48;
    localparam int PW = 2 * MW;
    localparam int SQ_W = 64;
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CROOT = 4'd1;
    localparam logic [3:0] S_VROOT = 4'd2;
    localparam logic [3:0] S_M1 = 4'd3;
    localparam logic [3:0] S_M2 = 4'd4;
    localparam logic [3:0] S_M3 = 4'd5;
    localparam logic [3:0] S_M4 = 4'd6;
    localparam logic [3:0] S_M5 = 4'd7;
    localparam logic [3:0] S_M6 = 4'd8;
    localparam logic [3:0] S_M7 = 4'd9;
    localparam logic [3:0] S_M8 = 4'd10;
    localparam logic [3:0] S_M9 = 4'd11;
    localparam logic [3:0] S_FIN = 4'd12;
    localparam logic [3:0] S_CSQ = 4'd13;
    localparam logic signed [MW-1:0] ONE = MW'(1) <<< FRAC_BITS;

    logic signed [31:0] mu_dt_reg;
    logic [16:0] sqrt_dt_reg;
    logic [16:0] kappa_dt_reg;
    logic [30:0] long_var_reg;
    logic [30:0] vol_var_reg;
    logic signed [17:0] corr_reg;
    logic [30:0] spot_reg;
    logic [30:0] init_var_reg;

    logic signed [31:0] cur_price_reg;
    logic [31:0] cur_var_reg;
    logic [31:0] comp_reg;
    logic [3:0] state_reg;
    logic pending_reg;
    logic signed [15:0] z1_reg;
    logic signed [15:0] z2_reg;
    logic signed [MW-1:0] sqv_reg;
    logic signed [MW-1:0] t_reg;
    logic signed [MW-1:0] w2_reg;
    logic signed [MW-1:0] mean_reg;
    logic signed [MW-1:0] noise_reg;
    logic signed [MW-1:0] drift_reg;

    logic out_valid_reg;
    logic signed [31:0] price_reg;
    logic [30:0] var_out_reg;
    logic sat_reg;
    logic trunc_reg;

    logic sq_start;
    logic sq_busy;
    logic mul_start;
    logic mul_busy;
    logic [SQ_W-1:0] sq_in;
    logic [SQ_W/2-1:0] sq_root;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] mul_shf;
    logic signed [PW-1:0] mul_shn;
    logic signed [MW-1:0] rho;
    logic signed [MW-1:0] rem_c;
    logic signed [MW+1:0] nv;
    logic signed [MW+1:0] np;

    // Clamp rho to [-1, 1].
    always_comb
    begin
        rho = MW'(corr_reg);
        if (rho > ONE)
        begin
            rho = ONE;
        end
        else if (rho < -ONE)
        begin
            rho = -ONE;
        end
    end

    assign mul_shf = mul_p >>> FRAC_BITS;
    assign mul_shn = mul_p >>> NORMAL_FRAC_BITS;
    assign rem_c = ONE - MW'(mul_shf);

    hes_isqrt #(.IN_W(SQ_W)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_in),
        .busy(sq_busy), .root(sq_root)
    );

    hes_serial_mul #(.A_W(MW), .B_W(MW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .busy(mul_busy), .product(mul_p)
    );

    assign in_ready = (state_reg == S_IDLE) && !pending_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_dt_reg <= '0;
            sqrt_dt_reg <= 17'd65536;
            kappa_dt_reg <= '0;
            long_var_reg <= 31'd2621;
            vol_var_reg <= '0;
            corr_reg <= '0;
            spot_reg <= 31'd6553600;
            init_var_reg <= 31'd2621;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MU_DT: mu_dt_reg <= cfg_data;
                REG_SQRT_DT: sqrt_dt_reg <= cfg_data[16:0];
                REG_KAPPA_DT: kappa_dt_reg <= cfg_data[16:0];
                REG_LONG_VAR: long_var_reg <= cfg_data[30:0];
                REG_VOL_VAR: vol_var_reg <= cfg_data[30:0];
                REG_CORR: corr_reg <= cfg_data[17:0];
                REG_SPOT: spot_reg <= cfg_data[30:0];
                REG_INIT_VAR: init_var_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Unit launches are driven combinationally from the sequencer state.
    logic launch_reg;
    always_comb
    begin
        sq_start = 1'b0;
        mul_start = 1'b0;
        sq_in = '0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CSQ:
            begin
                mul_start = launch_reg;
                mul_a = rho;
                mul_b = rho;
            end
            S_CROOT:
            begin
                sq_start = launch_reg;
                sq_in = (rem_c < 0) ? '0 : SQ_W'(rem_c) << FRAC_BITS;
            end
            S_VROOT:
            begin
                sq_start = launch_reg;
                sq_in = SQ_W'(cur_var_reg) << FRAC_BITS;
            end
            S_M1:
            begin
                mul_start = launch_reg;
                mul_a = rho;
                mul_b = MW'(z1_reg);
            end
            S_M2:
            begin
                mul_start = launch_reg;
                mul_a = MW'(comp_reg);
                mul_b = MW'(z2_reg);
            end
            S_M3:
            begin
                mul_start = launch_reg;
                mul_a = MW'(kappa_dt_reg);
                mul_b = MW'(long_var_reg) - MW'(cur_var_reg);
            end
            S_M4:
            begin
                mul_start = launch_reg;
                mul_a = MW'(vol_var_reg);
                mul_b = sqv_reg;
            end
            S_M5:
            begin
                mul_start = launch_reg;
                mul_a = t_reg;
                mul_b = w2_reg;
            end
            S_M6:
            begin
                mul_start = launch_reg;
                mul_a = MW'(mu_dt_reg);
                mul_b = MW'(cur_price_reg);
            end
            S_M7:
            begin
                mul_start = launch_reg;
                mul_a = sqv_reg;
                mul_b = MW'(sqrt_dt_reg);
            end
            S_M8:
            begin
                mul_start = launch_reg;
                mul_a = t_reg;
                mul_b = MW'(cur_price_reg);
            end
            S_M9:
            begin
                mul_start = launch_reg;
                mul_a = t_reg;
                mul_b = MW'(z1_reg);
            end
            default: ;
        endcase
    end

    assign nv = (MW+2)'(cur_var_reg) + (MW+2)'(mean_reg) + (MW+2)'(noise_reg);
    assign np = (MW+2)'(cur_price_reg) + (MW+2)'(drift_reg) + (MW+2)'(mul_shn);

    // Step sequencer: each unit state launches one unit pass and waits for it; idle and finish launch nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            launch_reg <= 1'b0;
            pending_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_price_reg <= 32'sd6553600;
            cur_var_reg <= 32'd2621;
            comp_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            launch_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        pending_reg <= 1'b1;
                        launch_reg <= 1'b1;
                        if (start_path)
                        begin
                            cur_price_reg <= 32'(spot_reg);
                            cur_var_reg <= 32'(init_var_reg);
                            state_reg <= S_CSQ;
                        end
                        else
                        begin
                            state_reg <= S_VROOT;
                        end
                    end
                end
                S_CSQ:
                begin
                    if (!launch_reg && !mul_busy)
                    begin
                        state_reg <= S_CROOT;
                        launch_reg <= 1'b1;
                    end
                end
                S_CROOT:
                begin
                    if (!launch_reg && !sq_busy)
                    begin
                        comp_reg <= sq_root;
                        state_reg <= S_VROOT;
                        launch_reg <= 1'b1;
                    end
                end
                S_VROOT:
                begin
                    if (!launch_reg && !sq_busy)
                    begin
                        state_reg <= S_M1;
                        launch_reg <= 1'b1;
                    end
                end
                S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8:
                begin
                    if (!launch_reg && !mul_busy)
                    begin
                        state_reg <= state_reg + 4'd1;
                        launch_reg <= 1'b1;
                    end
                end
                // The last pass waits here while an earlier result is still held.
                S_M9:
                begin
                    if (!launch_reg && !mul_busy && !out_valid_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        pending_reg <= 1'b0;
                        state_reg <= S_IDLE;
                        cur_var_reg <= 32'(var_out_reg);
                        cur_price_reg <= price_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath capture of the request samples and of the finished passes of a step.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            z1_reg <= z_price;
            z2_reg <= z_second;
        end
        if (!launch_reg)
        begin
            case (state_reg)
                S_VROOT: if (!sq_busy) sqv_reg <= MW'(sq_root);
                S_M1: if (!mul_busy) w2_reg <= MW'(mul_p);
                S_M2: if (!mul_busy) w2_reg <= MW'((PW'(w2_reg) + mul_p) >>> FRAC_BITS);
                S_M3: if (!mul_busy) mean_reg <= MW'(mul_shf);
                S_M4: if (!mul_busy) t_reg <= MW'(mul_shf);
                S_M5: if (!mul_busy) noise_reg <= MW'(mul_shn);
                S_M6: if (!mul_busy) drift_reg <= MW'(mul_shf);
                S_M7, S_M8: if (!mul_busy) t_reg <= MW'(mul_shf);
                S_M9:
                begin
                    if (!mul_busy && !out_valid_reg)
                    begin
                        sat_reg <= 1'b0;
                        trunc_reg <= 1'b0;
                        if (nv < 0)
                        begin
                            var_out_reg <= '0;
                            trunc_reg <= 1'b1;
                        end
                        else if (nv > (MW+2)'(32'h7FFFFFFF))
                        begin
                            var_out_reg <= 31'h7FFFFFFF;
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            var_out_reg <= nv[30:0];
                        end
                        if (np > (MW+2)'(32'sh7FFFFFFF))
                        begin
                            price_reg <= 32'sh7FFFFFFF;
                            sat_reg <= 1'b1;
                        end
                        else if (np < -(MW+2)'(64'sh80000000))
                        begin
                            price_reg <= 32'sh80000000;
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            price_reg <= np[31:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign price = price_reg;
    assign variance = var_out_reg;
    assign saturated = sat_reg;
    assign variance_truncated = trunc_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/heston_euler_path_step_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the stepper.
module heston_euler_path_step_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic variance_truncated,
    input wire logic [30:0] variance
);
    // A waiting result keeps its variance until taken.
    `ASSERT_NEXT(a_var_hold, clk, rst_n, out_valid && !out_ready, $stable(variance))
    // A waiting result stays until taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // A truncated variance is zero.
    `ASSERT_IMPL(a_trunc_zero, clk, rst_n, out_valid && variance_truncated, variance == 31'd0)
    // An accepted request leaves the block busy next cycle.
    `ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind heston_euler_path_step heston_euler_path_step_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .variance_truncated(variance_truncated), .variance(variance)
);
`default_nettype wire

// ----- dv/heston_euler_path_step_tb.sv -----
`timescale 1ns / 1ps
module heston_euler_path_step_tb;
    import hes_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 4000;
    localparam int PHASES = 13;
    localparam int ITEMS_PER_PHASE = 148;

    typedef struct {
        bit                 sp;
        logic signed [15:0] zp;
        logic signed [15:0] zs;
    } step_req_t;

    typedef struct {
        logic signed [31:0] price;
        logic [30:0]        variance;
        logic               saturated;
        logic               truncated;
    } step_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic start_path = 1'b0;
    logic signed [15:0] z_price = '0;
    logic signed [15:0] z_second = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] price;
    logic [30:0] variance;
    logic saturated;
    logic variance_truncated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    step_req_t pending_reqs[$];
    step_res_t expected_steps[$];
    bit failed = 1'b0;
    int idle_mode = 0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;
    int stall_cnt = 0;
    int issued_cnt = 0;
    int done_cnt = 0;

    // Shadow of the parameter registers and the path state.
    longint r_mu, r_sqrt_dt, r_kappa, r_long_var, r_vol, r_corr, r_spot, r_init_var;
    longint path_price, path_var, corr_comp;

    heston_euler_path_step u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_path(start_path), .z_price(z_price), .z_second(z_second),
        .out_valid(out_valid), .out_ready(out_ready),
        .price(price), .variance(variance), .saturated(saturated),
        .variance_truncated(variance_truncated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic longint floor_isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint rho_clamped();
        if (r_corr > 65536)
            return 65536;
        if (r_corr < -65536)
            return -65536;
        return r_corr;
    endfunction

    // Advance the shadow path by one Euler step and queue the result.
    task automatic euler_step(input step_req_t rq);
        longint rho, rem, z1, z2, w2, v, sqv, mean, noise, nv, drift, vs, diff, np;
        step_res_t res;
        bit sat;
        bit trunc;
        sat = 1'b0;
        trunc = 1'b0;
        if (rq.sp)
        begin
            path_price = r_spot;
            path_var = r_init_var;
            rho = rho_clamped();
            rem = 65536 - ((rho * rho) >>> 16);
            if (rem < 0)
                rem = 0;
            corr_comp = floor_isqrt(rem << 16);
        end
        z1 = longint'(rq.zp);
        z2 = longint'(rq.zs);
        rho = rho_clamped();
        w2 = (rho * z1 + corr_comp * z2) >>> 16;
        v = path_var;
        sqv = floor_isqrt(v << 16);
        mean = (r_kappa * (r_long_var - v)) >>> 16;
        noise = (r_vol * sqv) >>> 16;
        noise = (noise * w2) >>> 12;
        nv = v + mean + noise;
        if (nv < 0)
        begin
            nv = 0;
            trunc = 1'b1;
        end
        else if (nv > 64'h7FFF_FFFF)
        begin
            nv = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        drift = (r_mu * path_price) >>> 16;
        vs = (sqv * r_sqrt_dt) >>> 16;
        diff = (vs * path_price) >>> 16;
        diff = (diff * z1) >>> 12;
        np = path_price + drift + diff;
        if (np > 64'sh7FFF_FFFF)
        begin
            np = 64'sh7FFF_FFFF;
            sat = 1'b1;
        end
        else if (np < -64'sh8000_0000)
        begin
            np = -64'sh8000_0000;
            sat = 1'b1;
        end
        path_price = np;
        path_var = nv;
        res.price = np[31:0];
        res.variance = nv[30:0];
        res.saturated = sat;
        res.truncated = trunc;
        expected_steps.push_back(res);
    endtask

    function automatic bit sender_go();
        if (idle_mode == 1)
            return $urandom_range(0, 99) >= 86;
        if (idle_mode == 3)
            return $urandom_range(0, 99) >= 20;
        return 1'b1;
    endfunction

    function automatic bit receiver_go();
        if (hold_req && hold_cnt < HOLD_CYCLES)
            return 1'b0;
        if (idle_mode == 2)
            return $urandom_range(0, 99) >= 86;
        if (idle_mode == 3)
            return $urandom_range(0, 99) >= 20;
        return 1'b1;
    endfunction

    // Driver: presents queued requests and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        step_req_t rq;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                rq.sp = start_path;
                rq.zp = z_price;
                rq.zs = z_second;
                euler_step(rq);
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_reqs.size() > 0 && sender_go())
                begin
                    rq = pending_reqs.pop_front();
                    issued_cnt++;
                    in_valid <= 1'b1;
                    start_path <= rq.sp;
                    z_price <= rq.zp;
                    z_second <= rq.zs;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares every accepted result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        step_res_t ex;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                done_cnt++;
                if (expected_steps.size() == 0)
                begin
                    $error("unexpected result price=%0d variance=%0d", price, variance);
                    failed = 1'b1;
                end
                else
                begin
                    ex = expected_steps.pop_front();
                    if (price !== ex.price)
                    begin
                        $error("price expected %0d actual %0d", ex.price, price);
                        failed = 1'b1;
                    end
                    if (variance !== ex.variance)
                    begin
                        $error("variance expected %0d actual %0d", ex.variance, variance);
                        failed = 1'b1;
                    end
                    if (saturated !== ex.saturated)
                    begin
                        $error("saturated expected %0b actual %0b", ex.saturated, saturated);
                        failed = 1'b1;
                    end
                    if (variance_truncated !== ex.truncated)
                    begin
                        $error("variance_truncated expected %0b actual %0b",
                               ex.truncated, variance_truncated);
                        failed = 1'b1;
                    end
                end
            end
            out_ready <= receiver_go();
        end
    end

    // Long receiver hold-off, counted here once requested.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            if (hold_cnt < HOLD_CYCLES)
                hold_cnt <= hold_cnt + 1;
        end
        else
            hold_cnt <= 0;
    end

    // Watchdog on cycles with no request moving on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MU_DT:    r_mu = longint'($signed(val));
            REG_SQRT_DT:  r_sqrt_dt = longint'(val[16:0]);
            REG_KAPPA_DT: r_kappa = longint'(val[16:0]);
            REG_LONG_VAR: r_long_var = longint'(val[30:0]);
            REG_VOL_VAR:  r_vol = longint'(val[30:0]);
            REG_CORR:     r_corr = longint'($signed(val[17:0]));
            REG_SPOT:     r_spot = longint'(val[30:0]);
            REG_INIT_VAR: r_init_var = longint'(val[30:0]);
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] mu, sq, ka, lv, vo, co, sp, iv);
        write_reg(REG_MU_DT, mu);
        write_reg(REG_SQRT_DT, sq);
        write_reg(REG_KAPPA_DT, ka);
        write_reg(REG_LONG_VAR, lv);
        write_reg(REG_VOL_VAR, vo);
        write_reg(REG_CORR, co);
        write_reg(REG_SPOT, sp);
        write_reg(REG_INIT_VAR, iv);
    endtask

    task automatic add_step(input bit sp, input logic [15:0] zp, input logic [15:0] zs);
        step_req_t rq;
        rq.sp = sp;
        rq.zp = zp;
        rq.zs = zs;
        pending_reqs.push_back(rq);
    endtask

    // The test waits here until every queued request has been issued and has come back.
    task automatic drain();
        while (pending_reqs.size() > 0 || issued_cnt != done_cnt)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [15:0] normal_sample();
        if ($urandom_range(0, 15) == 0)
            return 16'($urandom());
        return 16'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    initial
    begin
        int ph;
        int n;
        logic [31:0] co;
        r_mu = 0;
        r_sqrt_dt = 65536;
        r_kappa = 0;
        r_long_var = 2621;
        r_vol = 0;
        r_corr = 0;
        r_spot = 6553600;
        r_init_var = 2621;
        path_price = r_spot;
        path_var = r_init_var;
        corr_comp = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        // Reset defaults, including steps before any path start.
        add_step(1'b0, 16'h7FFF, 16'h8000);
        add_step(1'b0, 16'h8000, 16'h7FFF);
        add_step(1'b0, 16'h0000, 16'h0000);
        add_step(1'b1, 16'h7FFF, 16'h7FFF);
        add_step(1'b0, 16'h8000, 16'h8000);
        drain();

        // Clamped correlation above one, large values that overflow.
        write_all(32'h7FFF_FFFF, 32'd65536, 32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0001_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_step(1'b1, 16'h7FFF, 16'h7FFF);
        add_step(1'b0, 16'h8000, 16'h0000);
        add_step(1'b1, 16'h4000, 16'h8000);
        add_step(1'b0, 16'h7FFF, 16'h1234);
        drain();

        // Correlation clamped below minus one, negative drift, negative variance.
        write_all(32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h00FF_FFFF,
                  32'h0002_0000, 32'h0064_0000, 32'h0000_4000);
        add_step(1'b1, 16'h7FFF, 16'h0000);
        add_step(1'b0, 16'h7FFF, 16'h7FFF);
        add_step(1'b0, 16'h8000, 16'h8000);
        drain();

        // Correlation changed mid-path keeps the old complement.
        write_reg(REG_CORR, 32'h0000_8000);
        write_reg(REG_VOL_VAR, 32'h0001_0000);
        add_step(1'b0, 16'h1000, 16'hF000);
        add_step(1'b0, 16'hF000, 16'h1000);
        add_step(1'b1, 16'h2000, 16'h2000);
        add_step(1'b0, 16'h0000, 16'h7FFF);
        drain();

        // Random phases, each with its own settings and idling pattern.
        for (ph = 0; ph < PHASES; ph++)
        begin
            idle_mode = ph % 4;
            if (ph % 4 == 3)
                write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom());
            else
            begin
                co = 32'($signed($urandom_range(0, 131072)) - 65536);
                write_all(32'($signed($urandom_range(0, 400)) - 200),
                          $urandom_range(0, 65536), $urandom_range(0, 8000),
                          $urandom_range(0, 20000), $urandom_range(0, 70000), co,
                          $urandom_range(0, 32'h0100_0000), $urandom_range(0, 40000));
            end
            hold_req = (ph == 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                add_step(n == 0 || $urandom_range(0, 9) == 0, normal_sample(),
                         normal_sample());
            drain();
            hold_req = 1'b0;
        end

        repeat (1000) @(posedge clk);
        if (!failed && expected_steps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/hes_pkg.sv
hw/rtl/hes_isqrt.sv
hw/rtl/hes_serial_mul.sv
hw/rtl/heston_euler_path_step.sv
hw/rtl/heston_euler_path_step_checker.sv
dv/heston_euler_path_step_tb.sv
